>>> src/mlci_pkg.sv
// ----------------------------------------------------------------------------
// mlci_pkg
// Transaction types and octant codes for the midpoint line color rasterizer.
// ----------------------------------------------------------------------------
package mlci_pkg;

    typedef struct packed {
        logic [5:0] start_x;
        logic [5:0] start_y;
        logic [5:0] end_x;
        logic [5:0] end_y;
        logic [7:0] start_red;
        logic [7:0] start_green;
        logic [7:0] start_blue;
        logic [7:0] end_red;
        logic [7:0] end_green;
        logic [7:0] end_blue;
    } t_line_cmd;

    typedef struct packed {
        logic [5:0] pixel_x;
        logic [5:0] pixel_y;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic       last_pixel;
    } t_pixel;

    localparam logic [2:0] MODE_VERT     = 3'd0;
    localparam logic [2:0] MODE_STEEP_UP = 3'd1;
    localparam logic [2:0] MODE_SHAL_UP  = 3'd2;
    localparam logic [2:0] MODE_SHAL_DN  = 3'd3;
    localparam logic [2:0] MODE_STEEP_DN = 3'd4;

    localparam int NUM_CHAN = 3;

endpackage

>>> src/mlci_div.sv
// ----------------------------------------------------------------------------
// mlci_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mlci_div
    import mlci_pkg::*;
#(
    parameter int COORD_BITS   = 6,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [CHANNEL_BITS-1:0] i_dividend,
    input  logic [COORD_BITS-1:0]   i_divisor,
    output logic                    o_done,
    output logic [CHANNEL_BITS-1:0] o_quot,
    output logic [COORD_BITS-1:0]   o_rem
);

    localparam int CNT_W = $clog2(CHANNEL_BITS + 1);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic [CHANNEL_BITS-1:0] r_quo;
    logic [COORD_BITS-1:0]   r_rem;
    logic [COORD_BITS-1:0]   r_dvs;
    logic [COORD_BITS:0]     w_sh;
    logic [COORD_BITS:0]     w_diff;
    logic                    w_ge;

    assign w_sh   = {r_rem, r_quo[CHANNEL_BITS-1]};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(CHANNEL_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[CHANNEL_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_diff[COORD_BITS-1:0] : w_sh[COORD_BITS-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

>>> src/midpoint_line_color_interp.sv
// ----------------------------------------------------------------------------
// midpoint_line_color_interp
// Midpoint line rasterizer with per-channel linear color interpolation.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one line command
// per transaction. Output channel (o_out_valid / i_out_ready / o_out_data)
// gives one pixel per transaction, lower-x end first (lower y on a tie), the
// other end excluded; the last pixel of each line carries last_pixel. A
// single-point line gives one pixel with the start color.
// After a command is taken, one shared serial divider splits each color
// difference by the major-axis length, one channel after another. The walk
// then loads one pixel per cycle into the output register while the
// receiver takes them; a single-point line skips the divider.
// o_in_ready rises once the last pixel is in the output register. A stalled
// receiver holds the output register and pauses the walk. Reset empties the
// output register and returns to idle.
// ----------------------------------------------------------------------------
module midpoint_line_color_interp
    import mlci_pkg::*;
#(
    parameter int COORD_BITS   = 6,
    parameter int CHANNEL_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_line_cmd i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_pixel    o_out_data
);

    localparam int CB = COORD_BITS;
    localparam int CW = CHANNEL_BITS;
    localparam int DW = COORD_BITS + 3;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;

    logic [1:0]           r_state;
    logic [1:0]           r_ch;
    logic                 r_div_go;
    logic [2:0]           r_mode;
    logic [CB-1:0]        r_n;
    logic [CB-1:0]        r_left;
    logic [CB-1:0]        r_px;
    logic [CB-1:0]        r_py;
    logic signed [DW-1:0] r_d;
    logic signed [DW-1:0] r_dx;
    logic signed [DW-1:0] r_dy;
    logic [CW-1:0]        r_cs [NUM_CHAN];
    logic [CW-1:0]        r_ce [NUM_CHAN];
    logic [CW-1:0]        r_q  [NUM_CHAN];
    logic [CB-1:0]        r_r  [NUM_CHAN];
    logic [CW-1:0]        r_cq [NUM_CHAN];
    logic [CB-1:0]        r_cr [NUM_CHAN];
    logic                 r_out_valid;
    t_pixel               r_out;

    logic                 w_in_acc;
    logic                 w_load;
    logic                 w_swap;
    logic [CB-1:0]        w_x0, w_y0, w_x1, w_y1;
    logic [CB-1:0]        w_dx;
    logic signed [CB:0]   w_dy;
    logic signed [DW-1:0] w_dxs, w_dys, w_ndy;
    logic [2:0]           n_mode;
    logic [CB-1:0]        n_n;
    logic signed [DW-1:0] n_d;
    logic [CW-1:0]        w_cs [NUM_CHAN];
    logic [CW-1:0]        w_ce [NUM_CHAN];

    logic                 w_div_done;
    logic [CW-1:0]        w_div_q;
    logic [CB-1:0]        w_div_r;
    logic                 w_neg;
    logic [CW-1:0]        w_mag;
    logic [CW-1:0]        w_qs;
    logic [CB-1:0]        w_rs;

    logic                 w_pos;
    logic signed [DW-1:0] w_da;
    logic                 w_xi, w_yi, w_yd;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_load     = (r_state == S_RUN) && (!r_out_valid || i_out_ready);

    // ---- setup: order endpoints, pick octant, length and decision start
    always_comb begin
        logic [CB-1:0] ax0, ay0, ax1, ay1;
        ax0 = CB'(i_in_data.start_x);
        ay0 = CB'(i_in_data.start_y);
        ax1 = CB'(i_in_data.end_x);
        ay1 = CB'(i_in_data.end_y);
        w_swap = (ax1 < ax0) || ((ax1 == ax0) && (ay1 < ay0));
        w_x0 = w_swap ? ax1 : ax0;
        w_y0 = w_swap ? ay1 : ay0;
        w_x1 = w_swap ? ax0 : ax1;
        w_y1 = w_swap ? ay0 : ay1;
        w_cs[0] = CW'(w_swap ? i_in_data.end_red   : i_in_data.start_red);
        w_cs[1] = CW'(w_swap ? i_in_data.end_green : i_in_data.start_green);
        w_cs[2] = CW'(w_swap ? i_in_data.end_blue  : i_in_data.start_blue);
        w_ce[0] = CW'(w_swap ? i_in_data.start_red   : i_in_data.end_red);
        w_ce[1] = CW'(w_swap ? i_in_data.start_green : i_in_data.end_green);
        w_ce[2] = CW'(w_swap ? i_in_data.start_blue  : i_in_data.end_blue);
        w_dx  = w_x1 - w_x0;
        w_dy  = $signed({1'b0, w_y1}) - $signed({1'b0, w_y0});
        w_dxs = $signed(DW'(w_dx));
        w_dys = DW'(w_dy);
        w_ndy = -w_dys;
        if (w_dx == '0) begin
            n_mode = MODE_VERT;
            n_n    = w_dy[CB-1:0];
            n_d    = '0;
        end else if (w_dys > w_dxs) begin
            n_mode = MODE_STEEP_UP;
            n_n    = w_dy[CB-1:0];
            n_d    = (w_dxs <<< 1) - w_dys;
        end else if (!w_dys[DW-1]) begin
            n_mode = MODE_SHAL_UP;
            n_n    = w_dx;
            n_d    = w_dxs - (w_dys <<< 1);
        end else if (w_ndy <= w_dxs) begin
            n_mode = MODE_SHAL_DN;
            n_n    = w_dx;
            n_d    = (w_ndy <<< 1) - w_dxs;
        end else begin
            n_mode = MODE_STEEP_DN;
            n_n    = w_ndy[CB-1:0];
            n_d    = -(w_dxs <<< 1) - w_dys;
        end
    end

    // ---- shared divider: |end - start| / n per channel, floored
    assign w_neg = (r_ce[r_ch] < r_cs[r_ch]);
    assign w_mag = w_neg ? (r_cs[r_ch] - r_ce[r_ch]) : (r_ce[r_ch] - r_cs[r_ch]);

    mlci_div #(
        .COORD_BITS   (COORD_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (w_mag),
        .i_divisor  (r_n),
        .o_done     (w_div_done),
        .o_quot     (w_div_q),
        .o_rem      (w_div_r)
    );

    always_comb begin
        if (!w_neg) begin
            w_qs = w_div_q;
            w_rs = w_div_r;
        end else if (w_div_r == '0) begin
            w_qs = -w_div_q;
            w_rs = '0;
        end else begin
            w_qs = ~w_div_q;
            w_rs = r_n - w_div_r;
        end
    end

    // ---- midpoint step
    assign w_pos = !r_d[DW-1] && (r_d != '0);

    always_comb begin
        w_xi = 1'b0;
        w_yi = 1'b0;
        w_yd = 1'b0;
        case (r_mode)
            MODE_VERT: begin
                w_da = '0;
                w_yi = 1'b1;
            end
            MODE_STEEP_UP: begin
                w_da = w_pos ? ((r_dx <<< 1) - (r_dy <<< 1)) : (r_dx <<< 1);
                w_xi = w_pos;
                w_yi = 1'b1;
            end
            MODE_SHAL_UP: begin
                w_da = w_pos ? -(r_dy <<< 1) : ((r_dx <<< 1) - (r_dy <<< 1));
                w_yi = !w_pos;
                w_xi = 1'b1;
            end
            MODE_SHAL_DN: begin
                w_da = w_pos ? (-(r_dy <<< 1) - (r_dx <<< 1)) : -(r_dy <<< 1);
                w_yd = w_pos;
                w_xi = 1'b1;
            end
            default: begin
                w_da = w_pos ? -(r_dx <<< 1) : (-(r_dx <<< 1) - (r_dy <<< 1));
                w_xi = !w_pos;
                w_yd = 1'b1;
            end
        endcase
    end

    // ---- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_ch <= '0;
                        if (n_n == '0) begin
                            r_state <= S_RUN;
                        end else begin
                            r_state  <= S_DIV;
                            r_div_go <= 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (r_ch == 2'(NUM_CHAN - 1)) begin
                            r_state <= S_RUN;
                        end else begin
                            r_ch     <= r_ch + 1'b1;
                            r_div_go <= 1'b1;
                        end
                    end
                end
                S_RUN: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        if (r_left == '0) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---- datapath
    always_ff @(posedge i_clk) begin
        logic [CB:0] sum;
        if (w_in_acc) begin
            r_mode <= n_mode;
            r_n    <= n_n;
            r_left <= (n_n == '0) ? '0 : n_n - 1'b1;
            r_px   <= w_x0;
            r_py   <= w_y0;
            r_d    <= n_d;
            r_dx   <= w_dxs;
            r_dy   <= w_dys;
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_cs[c] <= w_cs[c];
                r_ce[c] <= w_ce[c];
                r_q[c]  <= w_cs[c];
                r_r[c]  <= '0;
                r_cq[c] <= '0;
                r_cr[c] <= '0;
            end
        end else if ((r_state == S_DIV) && w_div_done) begin
            r_cq[r_ch] <= w_qs;
            r_cr[r_ch] <= w_rs;
        end else if (w_load) begin
            r_out.pixel_x     <= 6'(r_px);
            r_out.pixel_y     <= 6'(r_py);
            r_out.pixel_red   <= 8'(r_q[0]);
            r_out.pixel_green <= 8'(r_q[1]);
            r_out.pixel_blue  <= 8'(r_q[2]);
            r_out.last_pixel  <= (r_left == '0);
            r_left <= r_left - 1'b1;
            r_d    <= r_d + w_da;
            r_px   <= r_px + CB'(w_xi);
            r_py   <= w_yd ? (r_py - 1'b1) : (r_py + CB'(w_yi));
            for (int c = 0; c < NUM_CHAN; c++) begin
                sum = {1'b0, r_r[c]} + {1'b0, r_cr[c]};
                if (sum >= {1'b0, r_n}) begin
                    r_r[c] <= CB'(sum - {1'b0, r_n});
                    r_q[c] <= r_q[c] + r_cq[c] + 1'b1;
                end else begin
                    r_r[c] <= sum[CB-1:0];
                    r_q[c] <= r_q[c] + r_cq[c];
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- checks
    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ch <= 2'(NUM_CHAN - 1))
        else $error("channel select out of range");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_left == '0)) |=> (r_state == S_IDLE) && r_out.last_pixel)
        else $error("last pixel did not end the line");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("accepted a command without leaving idle");

    a_no_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |-> !w_load)
        else $error("pixel loaded outside the walk");

endmodule

>>> test/tb_midpoint_line_color_interp.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midpoint_line_color_interp
// Self-checking bench for the midpoint line rasterizer with color blending.
//
// Line commands go in through the valid/ready input channel, first a set of
// hand-picked lines (single points, vertical and horizontal lines, every slope
// octant, swapped endpoints, full-range coordinates and colors), then random
// lines under several sender and receiver idling mixes, plus one long receiver
// hold-off that backs up the input. Each accepted command is rasterized in the
// bench, and every pixel coming out is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_midpoint_line_color_interp;
    import mlci_pkg::*;

    class pixel_ledger;
        t_pixel pending_pixels[$];
        int     mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void rasterize_line(t_line_cmd cmd);
            int          x0, y0, x1, y1, dx, dy, d, x, y, t, n, cnt;
            int unsigned cs[NUM_CHAN];
            int unsigned ce[NUM_CHAN];
            int unsigned mix[NUM_CHAN];
            logic [2:0]  octant;
            t_pixel      px;
            x0 = cmd.start_x;
            y0 = cmd.start_y;
            x1 = cmd.end_x;
            y1 = cmd.end_y;
            cs[0] = cmd.start_red;
            cs[1] = cmd.start_green;
            cs[2] = cmd.start_blue;
            ce[0] = cmd.end_red;
            ce[1] = cmd.end_green;
            ce[2] = cmd.end_blue;
            if (x1 < x0 || (x1 == x0 && y1 < y0)) begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
                mix = cs;
                cs  = ce;
                ce  = mix;
            end
            dx = x1 - x0;
            dy = y1 - y0;
            d  = 0;
            if (dx == 0) begin
                octant = MODE_VERT;
                n      = dy;
            end else if (dy > dx) begin
                octant = MODE_STEEP_UP;
                n      = dy;
                d      = 2 * dx - dy;
            end else if (dy >= 0) begin
                octant = MODE_SHAL_UP;
                n      = dx;
                d      = dx - 2 * dy;
            end else if (-dy <= dx) begin
                octant = MODE_SHAL_DN;
                n      = dx;
                d      = -2 * dy - dx;
            end else begin
                octant = MODE_STEEP_DN;
                n      = -dy;
                d      = -2 * dx - dy;
            end
            cnt = (n == 0) ? 1 : n;
            x   = x0;
            y   = y0;
            for (int i = 0; i < cnt; i++) begin
                for (int c = 0; c < NUM_CHAN; c++) begin
                    if (n == 0) begin
                        mix[c] = cs[c];
                    end else begin
                        mix[c] = (cs[c] * (n - i) + ce[c] * i) / n;
                    end
                end
                px.pixel_x     = 6'(x);
                px.pixel_y     = 6'(y);
                px.pixel_red   = 8'(mix[0]);
                px.pixel_green = 8'(mix[1]);
                px.pixel_blue  = 8'(mix[2]);
                px.last_pixel  = (i == cnt - 1);
                pending_pixels.push_back(px);
                case (octant)
                    MODE_VERT: begin
                        y++;
                    end
                    MODE_STEEP_UP: begin
                        if (d > 0) begin
                            d += 2 * dx - 2 * dy;
                            x++;
                        end else begin
                            d += 2 * dx;
                        end
                        y++;
                    end
                    MODE_SHAL_UP: begin
                        if (d > 0) begin
                            d -= 2 * dy;
                        end else begin
                            d += 2 * dx - 2 * dy;
                            y++;
                        end
                        x++;
                    end
                    MODE_SHAL_DN: begin
                        if (d > 0) begin
                            d += -2 * dy - 2 * dx;
                            y--;
                        end else begin
                            d -= 2 * dy;
                        end
                        x++;
                    end
                    default: begin
                        if (d > 0) begin
                            d -= 2 * dx;
                        end else begin
                            d += -2 * dx - 2 * dy;
                            x++;
                        end
                        y--;
                    end
                endcase
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s expected %0d actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            if (pending_pixels.size() == 0) begin
                $error("pixel transaction with nothing expected: %h", got);
                mismatches++;
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("pixel_x", want.pixel_x, got.pixel_x);
            compare_field("pixel_y", want.pixel_y, got.pixel_y);
            compare_field("pixel_red", want.pixel_red, got.pixel_red);
            compare_field("pixel_green", want.pixel_green, got.pixel_green);
            compare_field("pixel_blue", want.pixel_blue, got.pixel_blue);
            compare_field("last_pixel", want.last_pixel, got.last_pixel);
        endfunction
    endclass

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    logic      out_ready  = 1'b0;
    t_line_cmd in_data    = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_pixel    o_out_data;

    pixel_ledger ledger = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    int send_idle_pcts[4] = '{0, 47, 0, 9};
    int stall_pcts[4]     = '{0, 0, 47, 9};

    midpoint_line_color_interp dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            ledger.check_pixel(o_out_data);
        end
        if (hold_served != hold_requests) begin
            hold_left   = 400;
            hold_served = hold_requests;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic t_line_cmd make_line(int sx, int sy, int ex, int ey,
                                            int sr, int sg, int sb,
                                            int er, int eg, int eb);
        t_line_cmd c;
        c.start_x     = 6'(sx);
        c.start_y     = 6'(sy);
        c.end_x       = 6'(ex);
        c.end_y       = 6'(ey);
        c.start_red   = 8'(sr);
        c.start_green = 8'(sg);
        c.start_blue  = 8'(sb);
        c.end_red     = 8'(er);
        c.end_green   = 8'(eg);
        c.end_blue    = 8'(eb);
        return c;
    endfunction

    function automatic t_line_cmd random_line();
        t_line_cmd   c;
        int unsigned kind;
        c = make_line($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        kind = $urandom_range(9);
        case (kind)
            0: begin
                c.end_x = c.start_x;
                c.end_y = c.start_y;
            end
            1: c.end_x = c.start_x;
            2: c.end_y = c.start_y;
            3, 4: begin
                c.end_x = 6'(int'(c.start_x) + int'($urandom_range(7)) - 3);
                c.end_y = 6'(int'(c.start_y) + int'($urandom_range(7)) - 3);
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic send_line(input t_line_cmd cmd);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        do @(posedge i_clk); while (!o_in_ready);
        ledger.rasterize_line(cmd);
    endtask

    initial begin
        #1_000_000;
        $display("midpoint_line_color_interp verification failed");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_line(make_line(0, 0, 0, 0, 255, 255, 255, 0, 0, 0));
        send_line(make_line(63, 63, 63, 63, 0, 0, 0, 255, 255, 255));
        send_line(make_line(5, 2, 5, 60, 0, 128, 255, 255, 128, 0));
        send_line(make_line(63, 63, 63, 0, 255, 0, 255, 0, 255, 0));
        send_line(make_line(0, 10, 63, 10, 0, 0, 0, 255, 255, 255));
        send_line(make_line(63, 40, 0, 40, 255, 255, 255, 0, 0, 0));
        send_line(make_line(0, 0, 63, 63, 10, 200, 30, 240, 20, 170));
        send_line(make_line(0, 63, 63, 0, 255, 1, 128, 0, 254, 127));
        send_line(make_line(10, 0, 20, 63, 17, 33, 99, 201, 5, 77));
        send_line(make_line(3, 60, 9, 1, 255, 0, 60, 0, 255, 190));
        send_line(make_line(0, 5, 50, 20, 90, 180, 45, 12, 240, 255));
        send_line(make_line(2, 40, 60, 30, 1, 2, 3, 254, 253, 252));
        send_line(make_line(30, 50, 25, 2, 100, 0, 200, 0, 100, 50));
        send_line(make_line(60, 0, 1, 10, 0, 255, 0, 255, 0, 255));
        send_line(make_line(7, 7, 8, 7, 200, 100, 50, 0, 0, 0));
        send_line(make_line(7, 7, 7, 8, 0, 0, 0, 200, 100, 50));
        send_line(make_line(0, 63, 1, 0, 255, 255, 255, 0, 0, 0));
        send_line(make_line(62, 0, 63, 63, 0, 0, 0, 255, 255, 255));
        send_line(make_line(20, 30, 40, 35, 128, 128, 128, 128, 128, 128));
        send_line(make_line(10, 10, 12, 11, 255, 255, 255, 0, 0, 0));

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = send_idle_pcts[phase];
            stall_pct     = stall_pcts[phase];
            for (int k = 0; k < 51; k++) begin
                send_line(random_line());
            end
            if (phase == 0) begin
                hold_requests++;
                for (int k = 0; k < 6; k++) begin
                    send_line(random_line());
                end
            end
        end
        in_valid <= 1'b0;

        while (ledger.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (ledger.mismatches == 0) begin
            $display("midpoint_line_color_interp verification clean");
        end else begin
            $display("midpoint_line_color_interp verification failed");
        end
        $finish;
    end

endmodule
